// File: rtl/tcme_pkg.sv
// Package: shared types and constants for the trunk charge median estimator.
`default_nettype none
package tcme_pkg;

    typedef struct packed {
        logic signed [23:0] hit_w;
        logic signed [23:0] hit_t;
        logic [19:0]        hit_charge;
        logic               last_hit;
    } t_in_item;

    typedef struct packed {
        logic [41:0] dqdx_value;
        logic [15:0] used_hits;
        logic [15:0] total_hits;
    } t_out_item;

    localparam logic [1:0] CFG_START_W = 2'd0;
    localparam logic [1:0] CFG_START_T = 2'd1;
    localparam logic [1:0] CFG_INV_DIR = 2'd2;
    localparam logic [1:0] CFG_TRUNK   = 2'd3;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQRT,
        S_SCALE,
        S_BINRD,
        S_BINWR,
        S_DECIDE,
        S_MCLR,
        S_MRD,
        S_MCMP,
        S_MNEXT,
        S_MUL,
        S_OUT,
        S_CLR
    } t_state;

endpackage
`default_nettype wire

// File: rtl/tcme_isqrt.sv
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module tcme_isqrt
    import tcme_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [48:0] i_radicand,
    output logic             o_done,
    output logic [24:0]      o_root
);
    logic [49:0] r_rem;
    logic [49:0] r_bit;
    logic [49:0] r_res;
    logic        r_busy;
    logic        r_done;
    logic [49:0] w_try;

    assign w_try  = r_res + r_bit;
    assign o_done = r_done;
    assign o_root = r_res[24:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= {1'b0, i_radicand};
                r_bit  <= 50'd1 << 48;
                r_res  <= '0;
            end else if (r_busy) begin
                if (r_rem >= w_try) begin
                    r_rem <= r_rem - w_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/trunk_charge_median_estimator_top.sv
// Top level of the trunk charge median estimator.
// Usage: hits of one cluster arrive on i_in_* (valid/ready), one hit per item.
// Registers are written on i_cfg_*; the user must write them only while the
// block is idle; the block itself does not enforce it. Each hit: two squares
// and their sum, then a bit-serial square root, a factor multiply and a bin
// read-modify-write. The block is not ready while a hit is in work.
// The last hit of a cluster also runs the median: for each of NUM_BINS bins a
// count of nonzero bins below and equal to it is taken by a pass over the bin
// memory, then one multiply by 1000 and one result item follow.
// The result waits in an output register while the receiver stalls; hits of
// the next cluster are still taken, and only the next result waits for it.
// Bins are then swept clear.
// After reset a clearing pass over all bins runs before any hit is taken.
// Results: dqdx_value = upper median of nonzero bins * 1000, plus hit counts.
`default_nettype none
module trunk_charge_median_estimator_top
    import tcme_pkg::*;
#(
    parameter int NUM_BINS = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);
    localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CW = $clog2(NUM_BINS + 1);

    logic signed [23:0] r_start_w, r_start_t;
    logic [15:0] r_inv;
    logic [12:0] r_trunk;

    logic [31:0] r_mem [NUM_BINS];
    logic [31:0] r_rd;

    t_state r_st, n_st;
    t_in_item r_hit;
    logic [15:0] r_used, r_total;
    logic [24:0] r_dw, r_dt;
    logic [48:0] r_sq;
    logic [24:0] r_root;
    logic [28:0] r_d;
    logic [BW-1:0] r_bin, r_i, r_j;
    logic [CW-1:0] r_nz, r_cnt_lt, r_cnt_eq;
    logic [31:0] r_cand, r_med;
    logic r_med_ok;
    logic [41:0] r_prod;
    t_out_item r_out;
    logic r_out_valid;
    logic r_sq_go, r_sq_go2, r_sq_go3;
    logic [48:0] r_dw2;

    logic sq_done;
    logic [24:0] sq_root;

    tcme_isqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_sq_go3),
        .i_radicand(r_sq), .o_done(sq_done), .o_root(sq_root)
    );

    logic signed [24:0] w_dw, w_dt;
    assign w_dw = 25'(i_in_data.hit_w) - 25'(r_start_w);
    assign w_dt = 25'(i_in_data.hit_t) - 25'(r_start_t);

    logic [41:0] w_d3;
    logic w_inside;
    logic [41:0] w_binfull;
    assign w_d3      = 42'(r_d) * 42'd3;
    assign w_binfull = w_d3 >> 8;
    assign w_inside  = (r_d < 29'(r_trunk)) && (w_binfull < 42'(NUM_BINS));

    logic [32:0] w_sum;
    assign w_sum = 33'(r_rd) + 33'(r_hit.hit_charge);

    logic w_last_i, w_last_j;
    assign w_last_i = (r_i == BW'(NUM_BINS - 1));
    assign w_last_j = (r_j == BW'(NUM_BINS - 1));

    // candidate sits at ascending position nz/2 among the nonzero bins
    logic w_med_hit;
    assign w_med_hit = (r_cand != 32'd0) && (r_cnt_lt <= (r_nz >> 1))
        && ({1'b0, r_nz >> 1} < ({1'b0, r_cnt_lt} + {1'b0, r_cnt_eq}));

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:   if (i_in_valid && o_in_ready) n_st = S_SQRT;
            S_SQRT:   if (sq_done) n_st = S_SCALE;
            S_SCALE:  n_st = S_BINRD;
            S_BINRD:  n_st = S_BINWR;
            S_BINWR:  n_st = S_DECIDE;
            S_DECIDE: n_st = r_hit.last_hit ? S_MCLR : S_IDLE;
            S_MCLR:   n_st = S_MRD;
            S_MRD:    n_st = S_MCMP;
            S_MCMP:   n_st = S_MNEXT;
            S_MNEXT:  n_st = (w_last_j && w_last_i) ? S_MUL :
                             (w_last_j ? S_MCLR : S_MRD);
            S_MUL:    n_st = S_OUT;
            S_OUT:    if (w_out_free) n_st = S_CLR;
            S_CLR:    if (w_last_i) n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    // bin memory: one write port and one read port, registered read
    always_ff @(posedge i_clk) begin
        if (r_st == S_CLR)
            r_mem[r_i] <= '0;
        else if (r_st == S_BINWR && w_inside)
            r_mem[r_bin] <= w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
        r_rd <= r_mem[(r_st == S_BINRD) ? w_binfull[BW-1:0] :
                      ((r_st == S_MCLR) ? r_i : r_j)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_i <= '0;
            r_out_valid <= 1'b0;
            r_used <= '0;
            r_total <= '0;
            r_start_w <= '0;
            r_start_t <= '0;
            r_inv <= 16'd4096;
            r_trunk <= '0;
            r_sq_go <= 1'b0;
            r_sq_go2 <= 1'b0;
            r_sq_go3 <= 1'b0;
        end else begin
            r_st <= n_st;
            r_sq_go <= 1'b0;
            r_sq_go2 <= r_sq_go;
            r_sq_go3 <= r_sq_go2;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_START_W: r_start_w <= i_cfg_data;
                    CFG_START_T: r_start_t <= i_cfg_data;
                    CFG_INV_DIR: r_inv <= i_cfg_data[15:0];
                    CFG_TRUNK:   r_trunk <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (r_st == S_OUT && w_out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_st)
                S_IDLE: if (i_in_valid && o_in_ready) begin
                    r_hit <= i_in_data;
                    r_dw <= w_dw[24] ? 25'(-w_dw) : 25'(w_dw);
                    r_dt <= w_dt[24] ? 25'(-w_dt) : 25'(w_dt);
                    r_sq_go <= 1'b1;
                    if (r_total != CNT_MAX) r_total <= r_total + 16'd1;
                end
                S_SQRT: begin
                    if (r_sq_go) r_dw2 <= 49'(r_dw) * 49'(r_dw);
                    if (r_sq_go) r_sq <= 49'(r_dt) * 49'(r_dt);
                    else if (r_sq_go2) r_sq <= r_sq + r_dw2;
                    if (sq_done) r_root <= sq_root;
                end
                S_SCALE: begin
                    r_d <= 29'((41'(r_root) * 41'(r_inv)) >> 12);
                    r_bin <= '0;
                end
                S_BINRD: r_bin <= w_binfull[BW-1:0];
                S_BINWR: if (w_inside && r_used != CNT_MAX) r_used <= r_used + 16'd1;
                S_DECIDE: begin
                    r_i <= '0;
                    r_nz <= '0;
                    r_med_ok <= 1'b0;
                    r_med <= '0;
                end
                S_MCLR: begin
                    r_j <= '0;
                    r_cnt_lt <= '0;
                    r_cnt_eq <= '0;
                    // counts of the previous column are complete here
                    if (r_i != '0 && !r_med_ok && w_med_hit) begin
                        r_med <= r_cand;
                        r_med_ok <= 1'b1;
                    end
                end
                S_MRD: begin
                    if (r_j == '0) r_cand <= r_rd;
                end
                S_MCMP: ;
                S_MNEXT: begin
                    if (r_rd != 32'd0 && r_rd < r_cand) r_cnt_lt <= r_cnt_lt + 1'b1;
                    if (r_rd != 32'd0 && r_rd == r_cand) r_cnt_eq <= r_cnt_eq + 1'b1;
                    if (r_i == '0 && r_rd != 32'd0) r_nz <= r_nz + 1'b1;
                    r_j <= r_j + 1'b1;
                    if (w_last_j) r_i <= r_i + 1'b1;
                end
                S_MUL: r_prod <= 42'((!r_med_ok && w_med_hit) ? r_cand : r_med) * 42'd1000;
                S_OUT: if (w_out_free) begin
                    r_out.dqdx_value <= r_prod;
                    r_out.used_hits  <= r_used;
                    r_out.total_hits <= r_total;
                    r_used <= '0;
                    r_total <= '0;
                    r_i <= '0;
                end
                S_CLR: r_i <= r_i + 1'b1;
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_st == S_IDLE)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_used_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_total) else $error("used above total");
endmodule
`default_nettype wire
